// ===== design/tlvdie_pkg.sv =====
// Package for the TLV die-record ID extractor.
// Holds the transaction payload types and the shared constants; no dependencies.
package tlvdie_pkg;

	localparam int unsigned CapBytes = 12;
	localparam int unsigned CapIdxW  = $clog2(CapBytes);
	localparam logic [CapIdxW-1:0] CapLastIdx = CapIdxW'(CapBytes - 1);
	localparam logic [7:0] RecordTagReset = 8'd8;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       region_end;
	} in_item_t;

	typedef struct packed {
		logic [63:0] device_id;
		logic        found;
	} out_item_t;

endpackage

// ===== design/tlv_die_record_id_extractor.sv =====
// Top level of the TLV die-record ID extractor.
// Depends on tlvdie_pkg and tlvdie_capture.
//
// The block parses a tag-length-value byte region arriving one byte per input
// transaction on in_valid / in_stall / in_item. A record whose tag equals the
// configured record tag has its length byte ignored and its next twelve bytes
// captured: wafer, X and Y words (little-endian), then six lot bytes. When the
// twelfth byte arrives, one result transaction carries the combined 64-bit ID
// with found set. If the region ends (region_end set) before any record was
// completed, one result with a zero ID and found clear is produced instead.
// Every region therefore yields exactly one result, and parsing restarts
// after its last byte.
// Results leave on out_valid / out_stall / out_item from the output register.
// A byte is accepted every cycle; the only limit is the output register plus a
// one-entry skid register, so in_stall rises only when the skid register holds
// a result that the receiver has not yet taken.
// The record tag is written on cfg_valid / cfg_ready / cfg_data, which is
// always ready. Reset sets the tag to 8, returns the parser to expecting a
// tag and empties both output registers. Captured bytes are not reset; they
// are only read once all twelve have been written.
module tlv_die_record_id_extractor (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  tlvdie_pkg::in_item_t   in_item,
	output logic                   out_valid,
	input  logic                   out_stall,
	output tlvdie_pkg::out_item_t  out_item,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [7:0]             cfg_data
);
	import tlvdie_pkg::*;

	typedef enum logic [2:0] {
		PH_TAG,
		PH_LEN,
		PH_SKIP,
		PH_CAP,
		PH_DONE
	} phase_t;

	phase_t     phase_q;
	logic [7:0] byte_count_q;
	logic       pending_match_q;
	logic [7:0] record_tag_q;

	logic       out_valid_q;
	out_item_t  out_item_q;
	logic       skid_valid_q;
	out_item_t  skid_item_q;

	logic       in_accept;
	logic       cap_wr;
	logic       cap_done;
	logic       emit;
	out_item_t  result;
	logic [63:0] cap_id;

	assign cfg_ready = 1'b1;
	assign in_stall  = skid_valid_q;
	assign in_accept = in_valid && !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			record_tag_q <= RecordTagReset;
		end else if (cfg_valid) begin
			record_tag_q <= cfg_data;
		end
	end

	// Capture writes land at the running capture count; the count never passes
	// the last capture slot while in the capture phase.
	assign cap_wr   = in_accept && (phase_q == PH_CAP);
	assign cap_done = cap_wr && (byte_count_q[CapIdxW-1:0] == CapLastIdx);

	tlvdie_capture u_capture (
		.clk       (clk),
		.wr_en     (cap_wr),
		.wr_idx    (byte_count_q[CapIdxW-1:0]),
		.wr_byte   (in_item.data_byte),
		.device_id (cap_id)
	);

	// A completed record always wins; otherwise the end of a region without a
	// record produces the empty result.
	always_comb begin
		emit = 1'b0;
		result.device_id = cap_id;
		result.found = 1'b1;
		if (cap_done) begin
			emit = 1'b1;
		end else if (in_accept && in_item.region_end && (phase_q != PH_DONE)) begin
			emit = 1'b1;
			result.device_id = '0;
			result.found = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TAG;
			byte_count_q <= '0;
			pending_match_q <= 1'b0;
		end else if (in_accept) begin
			if (in_item.region_end) begin
				phase_q <= PH_TAG;
				byte_count_q <= '0;
				pending_match_q <= 1'b0;
			end else begin
				unique case (phase_q)
					PH_TAG: begin
						pending_match_q <= (in_item.data_byte == record_tag_q);
						phase_q <= PH_LEN;
					end
					PH_LEN: begin
						priority if (pending_match_q) begin
							byte_count_q <= '0;
							phase_q <= PH_CAP;
						end else if (in_item.data_byte == 8'd0) begin
							phase_q <= PH_TAG;
						end else begin
							byte_count_q <= in_item.data_byte;
							phase_q <= PH_SKIP;
						end
					end
					PH_SKIP: begin
						byte_count_q <= byte_count_q - 8'd1;
						if (byte_count_q == 8'd1) begin
							phase_q <= PH_TAG;
						end
					end
					PH_CAP: begin
						byte_count_q <= byte_count_q + 8'd1;
						if (cap_done) begin
							phase_q <= PH_DONE;
						end
					end
					PH_DONE: begin
						phase_q <= PH_DONE;
					end
					default: begin
						phase_q <= PH_TAG;
					end
				endcase
			end
		end
	end

	// Output register with a one-entry skid register behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q || !out_stall) begin
				if (skid_valid_q) begin
					out_valid_q <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= emit;
				end
			end else if (emit) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || !out_stall) begin
			if (skid_valid_q) begin
				out_item_q <= skid_item_q;
			end else if (emit) begin
				out_item_q <= result;
			end
		end else if (emit) begin
			skid_item_q <= result;
		end
	end

endmodule

// ===== design/tlvdie_capture.sv =====
// Capture store for the twelve die-record bytes and the ID combiner.
// Depends on tlvdie_pkg.
module tlvdie_capture (
	input  logic                             clk,
	input  logic                             wr_en,
	input  logic [tlvdie_pkg::CapIdxW-1:0]   wr_idx,
	input  logic [7:0]                       wr_byte,
	output logic [63:0]                      device_id
);
	import tlvdie_pkg::*;

	logic [7:0] record_bytes_q [CapBytes];
	logic [15:0] wafer;
	logic [15:0] xpos;
	logic [15:0] ypos;
	logic [47:0] lot;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			record_bytes_q[wr_idx] <= wr_byte;
		end
	end

	// The last lot byte is the byte arriving now, so the ID is ready on that same transaction.
	always_comb begin
		wafer = {record_bytes_q[1], record_bytes_q[0]};
		xpos  = {record_bytes_q[3], record_bytes_q[2]};
		ypos  = {record_bytes_q[5], record_bytes_q[4]};
		lot   = {record_bytes_q[6], record_bytes_q[7], record_bytes_q[8],
			record_bytes_q[9], record_bytes_q[10], wr_byte};
		device_id = {lot, wafer} ^ {16'h0000, xpos, 16'h0000, ypos};
	end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the TLV die-record ID extractor.
// Depends on tlvdie_pkg and the tlv_die_record_id_extractor RTL; needs no files or arguments.
// Feeds byte regions, predicts each region's ID result, and compares the results field by field.
module tb_top;
	import tlvdie_pkg::*;

	localparam int ItemTarget    = 650;
	localparam int SettleCycles  = 6;
	localparam int WatchdogLimit = 3000;

	// States of the parser as this testbench tracks it.
	typedef enum logic [2:0] {
		TAG_NEXT,
		LEN_NEXT,
		SKIPPING,
		CAPTURING,
		RECORD_DONE
	} parse_phase_t;

	// Shapes of random regions.
	typedef enum int {
		REGION_GOOD,
		REGION_NO_RECORD,
		REGION_CUT,
		REGION_NOISE
	} region_kind_t;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	in_item_t    in_item   = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_item;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data  = '0;

	// Bytes waiting to be driven, and the ID results that the accepted bytes call for.
	in_item_t    pending_bytes [$];
	out_item_t   expected_ids [$];

	// Mirror of the parser state, kept up to date on every accepted byte.
	logic [7:0]   tag_value = RecordTagReset;
	parse_phase_t phase = TAG_NEXT;
	logic [7:0]   byte_count = '0;
	logic [7:0]   captured [CapBytes];
	logic         tag_hit = 1'b0;
	logic         record_seen = 1'b0;

	int  send_idle_pct = 0;
	int  recv_stall_pct = 0;
	int  errors = 0;
	int  idle_cycles = 0;
	int  cfg_writes = 0;
	int  planned_items = 0;
	bit  byte_taken = 1'b0;
	bit  byte_in_flight = 1'b0;

	tlv_die_record_id_extractor u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		errors++;
	endtask

	// The ID is the six lot bytes (first one on top) over the wafer word, with the
	// X word folded into bits 47:32 and the Y word into bits 15:0 by XOR.
	function automatic logic [63:0] combine_die_id();
		logic [47:0] lot;
		logic [63:0] base;
		lot  = {captured[6], captured[7], captured[8], captured[9], captured[10], captured[11]};
		base = {lot, captured[1], captured[0]};
		return base ^ {16'h0000, captured[3], captured[2], 16'h0000, captured[5], captured[4]};
	endfunction

	// Advances the mirrored parser by one accepted byte and queues the ID result,
	// if the byte causes one.
	task automatic parse_byte(input in_item_t it);
		bit        emitted;
		out_item_t res;
		emitted = 1'b0;
		case (phase)
			TAG_NEXT: begin
				tag_hit = (it.data_byte == tag_value);
				phase   = LEN_NEXT;
			end
			LEN_NEXT: begin
				// The length of a matching record is not used: exactly twelve bytes follow.
				if (tag_hit) begin
					byte_count = '0;
					phase      = CAPTURING;
				end else if (it.data_byte == 8'd0) begin
					phase = TAG_NEXT;
				end else begin
					byte_count = it.data_byte;
					phase      = SKIPPING;
				end
			end
			SKIPPING: begin
				byte_count = byte_count - 8'd1;
				if (byte_count == 8'd0)
					phase = TAG_NEXT;
			end
			CAPTURING: begin
				captured[byte_count[CapIdxW-1:0]] = it.data_byte;
				byte_count = byte_count + 8'd1;
				if (byte_count == 8'(CapBytes)) begin
					res.device_id = combine_die_id();
					res.found     = 1'b1;
					expected_ids.push_back(res);
					emitted     = 1'b1;
					record_seen = 1'b1;
					phase       = RECORD_DONE;
				end
			end
			default: ;
		endcase
		// A region that closes without a finished record still reports once, with a zero ID.
		if (it.region_end) begin
			if (!emitted && !record_seen) begin
				res.device_id = '0;
				res.found     = 1'b0;
				expected_ids.push_back(res);
			end
			phase       = TAG_NEXT;
			byte_count  = '0;
			tag_hit     = 1'b0;
			record_seen = 1'b0;
		end
	endtask

	// Driver: a new byte is presented at the falling edge once the previous one
	// was taken, so a stalled transaction keeps its payload.
	always @(negedge clk) begin
		if (arst_n) begin
			if (byte_taken || !in_valid) begin
				byte_taken = 1'b0;
				if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_item        <= pending_bytes.pop_front();
					in_valid       <= 1'b1;
					byte_in_flight = 1'b1;
				end else begin
					in_valid       <= 1'b0;
					byte_in_flight = 1'b0;
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Monitor: every handshake is sampled at the rising edge. Input transactions
	// feed the mirrored parser, output transactions are checked against the
	// oldest expected ID, and a run of edges with no transaction at all trips
	// the watchdog.
	always @(posedge clk) begin : monitor
		bit        moved;
		out_item_t want;
		moved = 1'b0;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				parse_byte(in_item);
				byte_taken = 1'b1;
				moved      = 1'b1;
			end
			if (out_valid && !out_stall) begin
				moved = 1'b1;
				if (expected_ids.size() == 0) begin
					report_mismatch($sformatf("result with nothing expected: id %h found %b",
						out_item.device_id, out_item.found));
				end else begin
					want = expected_ids.pop_front();
					if (out_item.device_id !== want.device_id)
						report_mismatch($sformatf("device_id %h, expected %h",
							out_item.device_id, want.device_id));
					if (out_item.found !== want.found)
						report_mismatch($sformatf("found %b, expected %b",
							out_item.found, want.found));
				end
			end
			if (cfg_valid && cfg_ready) begin
				tag_value = cfg_data;
				cfg_writes++;
				moved = 1'b1;
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= WatchdogLimit) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	task automatic queue_byte(input logic [7:0] b, input logic last_byte);
		in_item_t it;
		it.data_byte  = b;
		it.region_end = last_byte;
		pending_bytes.push_back(it);
		planned_items++;
	endtask

	// Builds one region of the given kind for the given die-record tag. Every
	// byte of the region counts toward the item budget.
	task automatic queue_region(input logic [7:0] die_tag, input region_kind_t kind);
		logic [7:0] region [$];
		logic [7:0] rtag;
		logic [7:0] len;
		int         n;
		if (kind == REGION_NOISE) begin
			n = $urandom_range(1, 16);
			repeat (n) region.push_back(8'($urandom_range(0, 255)));
		end else begin
			n = $urandom_range(0, 3);
			repeat (n) begin
				rtag = 8'($urandom_range(0, 255));
				if (rtag == die_tag)
					rtag = rtag ^ 8'h01;
				len = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255))
					: 8'($urandom_range(0, 6));
				region.push_back(rtag);
				region.push_back(len);
				repeat (len) region.push_back(8'($urandom_range(0, 255)));
			end
			if (kind == REGION_GOOD) begin
				region.push_back(die_tag);
				region.push_back(8'($urandom_range(0, 255)));
				repeat (CapBytes) region.push_back(8'($urandom_range(0, 255)));
				n = $urandom_range(0, 3);
				repeat (n) region.push_back(8'($urandom_range(0, 255)));
			end else if (kind == REGION_CUT) begin
				// Cut on the tag, on the length or anywhere inside the capture.
				region.push_back(die_tag);
				n = $urandom_range(0, CapBytes);
				if (n > 0)
					region.push_back(8'($urandom_range(0, 255)));
				repeat (n - 1) region.push_back(8'($urandom_range(0, 255)));
			end
			if (region.size() == 0)
				region.push_back(8'($urandom_range(0, 255)));
		end
		foreach (region[i])
			queue_byte(region[i], i == region.size() - 1);
	endtask

	// Waits until every byte has been taken and every expected ID has come back,
	// then lets the output registers settle.
	task automatic wait_idle();
		while (pending_bytes.size() != 0 || byte_in_flight || expected_ids.size() != 0)
			@(negedge clk);
		repeat (SettleCycles) @(negedge clk);
	endtask

	task automatic write_tag(input logic [7:0] value);
		int seen;
		seen = cfg_writes;
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		while (cfg_writes == seen)
			@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic queue_directed();
		// A die record at the reset tag whose last capture byte also ends the
		// region, with all-ones, all-zeros and single-bit field values.
		queue_byte(RecordTagReset, 1'b0);
		queue_byte(8'd12, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'h80, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h01, 1'b0);
		queue_byte(8'hFE, 1'b0);
		queue_byte(8'h7F, 1'b0);
		queue_byte(8'hA5, 1'b1);
		// A zero-length record, a one-byte skip, then the region ends on a tag.
		queue_byte(8'd3, 1'b0);
		queue_byte(8'd0, 1'b0);
		queue_byte(8'd5, 1'b0);
		queue_byte(8'd1, 1'b0);
		queue_byte(8'hAA, 1'b0);
		queue_byte(8'h00, 1'b1);
		// A region of a single byte.
		queue_byte(8'hFF, 1'b1);
		// A matching record with the largest length byte, cut after three bytes.
		queue_byte(RecordTagReset, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'h11, 1'b0);
		queue_byte(8'h22, 1'b0);
		queue_byte(8'h33, 1'b1);
	endtask

	initial begin : stimulus
		int          roll;
		logic [7:0]  next_tag;
		region_kind_t kind;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int p = 0; p < 4; p++) begin
			if (p > 0) begin
				wait_idle();
				case (p)
					1: next_tag = 8'h00;
					2: next_tag = 8'hFF;
					default: next_tag = 8'($urandom_range(0, 255));
				endcase
				write_tag(next_tag);
			end
			case (p)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
				default: begin send_idle_pct = 30; recv_stall_pct = 30; end
			endcase
			if (p == 0)
				queue_directed();
			while (planned_items < ItemTarget * (p + 1) / 4) begin
				roll = $urandom_range(0, 99);
				if (roll < 60)
					kind = REGION_GOOD;
				else if (roll < 75)
					kind = REGION_NO_RECORD;
				else if (roll < 90)
					kind = REGION_CUT;
				else
					kind = REGION_NOISE;
				queue_region(tag_value, kind);
			end
		end

		wait_idle();
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== tlv_die_record_id_extractor.f =====
design/tlvdie_pkg.sv
design/tlvdie_capture.sv
design/tlv_die_record_id_extractor.sv
tb/tb_top.sv
